[rtl/lslf_pkg.sv]
package lslf_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PT_XX,
    S_PT_XY,
    S_PT_ADD,
    S_MUL,
    S_CHK_DEN,
    S_DIV_LOAD,
    S_DIV_STEP,
    S_DIV_RND,
    S_DIV_SAT,
    S_DONE
  } state_t;

  // which cross-product difference the multiply sequence builds
  typedef enum logic [1:0] {
    EXPR_DEN,
    EXPR_NB,
    EXPR_NA
  } expr_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_DROP  = 2'd2;

  localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000_0000;

endpackage

[rtl/least_squares_line_fit_unit.sv]
// Least-squares line fit y = a + b*x over a set of (x, y) points.
// Input channel (in_valid/in_ready): one point per beat, x_value, y_value and
// last_point. The beat with last_point set is itself a point and closes the set.
// Output channel (out_valid/out_ready): one beat per set with slope, intercept
// (signed, FRAC_BITS fraction bits, saturated to 64 bits) and fit_status
// (0 ok, 1 degenerate, 2 points were dropped).
// An accepted point passes through S_PT_XX, S_PT_XY and S_PT_ADD before the
// block is ready again, using the one shared 32x32 multiplier for x*x, then
// x*y. A point beyond MAX_POINTS is dropped.
// After the closing point the same multiplier forms the three cross products
// from 32-bit partial products, and one restoring divider produces one
// quotient bit per cycle for the slope, then the intercept. When the fit is
// degenerate the divisions are skipped. The block takes no point until the
// result has gone into the output register.
// The result sits in an output register: the block takes new points while it
// waits to be taken, and a further fit stalls in its last step until the
// register is free. Reset clears the sums, the count and the output valid.
module least_squares_line_fit_unit
  import lslf_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] x_value,
  input  logic signed [31:0] y_value,
  input  logic               last_point,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] slope,
  output logic signed [63:0] intercept,
  output logic [1:0]         fit_status
);

  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int SXW  = 16 + CW;
  localparam int SXXW = 30 + CW;
  localparam int SYW  = 32 + CW;
  localparam int SXYW = 47 + CW;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

  state_t state, state_next;
  expr_t  expr;

  logic [CW-1:0]          point_count;
  logic signed [SXW-1:0]  sum_x;
  logic [SXXW-1:0]        sum_x_squared;
  logic signed [SYW-1:0]  sum_y;
  logic signed [SXYW-1:0] sum_xy;
  logic                   overflow_seen;

  logic [15:0]  x_mag;
  logic [31:0]  y_mag;
  logic         xy_neg;
  logic         last_r;
  logic [63:0]  prod;
  logic [127:0] acc;
  logic [3:0]   step;
  logic [6:0]   div_cnt;
  logic [63:0]  rem;
  logic [63:0]  den;
  logic         degen;
  logic         div_neg;
  logic         div_sel;
  logic [63:0]  slope_r;
  logic [63:0]  intercept_r;

  logic         in_fire;
  logic         room;
  logic         out_load;
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  mul_p;
  logic [63:0]  n64, sx64, sxx64, sy64, sxy64;
  logic [63:0]  op_a, op_b, a_mag, b_mag;
  logic         prod_neg;
  logic [6:0]   sh_amt;
  logic [127:0] term, term_s;
  logic [63:0]  xy_term;
  logic         den_bad;
  logic [127:0] div_shift, div_mag;
  logic [64:0]  rem_ext, rem_diff;
  logic         div_ge;
  logic         rnd_up;
  logic [63:0]  sat_val;

  assign in_fire  = in_valid && in_ready;
  assign room     = point_count < MAX_CNT;
  assign out_load = !out_valid || out_ready;

  // shared multiplier
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // operands of the cross products, extended to 64 bits
  assign n64   = 64'(point_count);
  assign sx64  = 64'(sum_x);
  assign sxx64 = 64'(sum_x_squared);
  assign sy64  = 64'(sum_y);
  assign sxy64 = 64'(sum_xy);

  // step[0] multiply/add phase, step[2:1] partial product, step[3] second product
  always_comb begin
    unique case (expr)
      EXPR_DEN: begin
        op_a = step[3] ? sx64 : n64;
        op_b = step[3] ? sx64 : sxx64;
      end
      EXPR_NB: begin
        op_a = step[3] ? sx64 : n64;
        op_b = step[3] ? sy64 : sxy64;
      end
      EXPR_NA: begin
        op_a = step[3] ? sx64 : sxx64;
        op_b = step[3] ? sxy64 : sy64;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign a_mag    = op_a[63] ? -op_a : op_a;
  assign b_mag    = op_b[63] ? -op_b : op_b;
  // second product is subtracted
  assign prod_neg = op_a[63] ^ op_b[63] ^ step[3];
  assign sh_amt   = {2'(step[1]) + 2'(step[2]), 5'b0};
  assign term     = {64'b0, prod} << sh_amt;
  assign term_s   = prod_neg ? -term : term;

  assign xy_term = xy_neg ? -prod : prod;
  assign den_bad = (|acc[127:64]) || (acc[63:0] == 64'd0);

  assign div_shift = acc << FRAC_BITS;
  assign div_mag   = div_shift[127] ? -div_shift : div_shift;
  assign rem_ext   = {rem, acc[127]};
  assign rem_diff  = rem_ext - {1'b0, den};
  assign div_ge    = rem_ext >= {1'b0, den};
  assign rnd_up    = rem >= (den - rem);

  always_comb begin
    if (div_neg) begin
      sat_val = ((|acc[127:64]) || (acc[63:0] > SAT_NEG)) ? SAT_NEG : -acc[63:0];
    end else begin
      sat_val = ((|acc[127:64]) || acc[63]) ? SAT_POS : acc[63:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (room) begin
            state_next = S_PT_XX;
          end else if (last_point) begin
            state_next = S_MUL;
          end
        end
      end
      S_PT_XX:  state_next = S_PT_XY;
      S_PT_XY:  state_next = S_PT_ADD;
      S_PT_ADD: state_next = last_r ? S_MUL : S_IDLE;
      S_MUL: begin
        if (step == 4'hF) begin
          state_next = (expr == EXPR_DEN) ? S_CHK_DEN : S_DIV_LOAD;
        end
      end
      S_CHK_DEN:  state_next = den_bad ? S_DONE : S_MUL;
      S_DIV_LOAD: state_next = S_DIV_STEP;
      S_DIV_STEP: begin
        if (div_cnt == 7'h7F) begin
          state_next = S_DIV_RND;
        end
      end
      S_DIV_RND: state_next = S_DIV_SAT;
      S_DIV_SAT: state_next = div_sel ? S_DONE : S_MUL;
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = (state == S_IDLE);
    unique case (state)
      S_PT_XX: begin
        mul_a = {16'b0, x_mag};
        mul_b = {16'b0, x_mag};
      end
      S_PT_XY: begin
        mul_a = {16'b0, x_mag};
        mul_b = y_mag;
      end
      S_MUL: begin
        mul_a = step[1] ? a_mag[63:32] : a_mag[31:0];
        mul_b = step[2] ? b_mag[63:32] : b_mag[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // control and running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      point_count   <= '0;
      sum_x         <= '0;
      sum_x_squared <= '0;
      sum_y         <= '0;
      sum_xy        <= '0;
      overflow_seen <= 1'b0;
      step          <= '0;
      div_cnt       <= '0;
      expr          <= EXPR_DEN;
      div_sel       <= 1'b0;
      degen         <= 1'b0;
    end else begin
      state   <= state_next;
      step    <= (state == S_MUL) ? step + 4'd1 : 4'd0;
      div_cnt <= (state == S_DIV_STEP) ? div_cnt + 7'd1 : 7'd0;

      if (state == S_DONE && out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          expr <= EXPR_DEN;
          if (in_fire) begin
            if (room) begin
              point_count <= point_count + CW'(1);
              sum_x       <= sum_x + SXW'(x_value);
              sum_y       <= sum_y + SYW'(y_value);
            end else begin
              overflow_seen <= 1'b1;
            end
          end
        end
        S_PT_XY: sum_x_squared <= sum_x_squared + prod[SXXW-1:0];
        S_PT_ADD: sum_xy <= sum_xy + xy_term[SXYW-1:0];
        S_CHK_DEN: begin
          expr    <= EXPR_NB;
          div_sel <= 1'b0;
          degen   <= den_bad;
        end
        S_DIV_SAT: begin
          expr    <= EXPR_NA;
          div_sel <= 1'b1;
        end
        S_DONE: begin
          if (out_load) begin
            point_count   <= '0;
            sum_x         <= '0;
            sum_x_squared <= '0;
            sum_y         <= '0;
            sum_xy        <= '0;
            overflow_seen <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_p;

    unique case (state)
      S_IDLE: begin
        acc <= '0;
        if (in_fire) begin
          x_mag  <= x_value[15] ? 16'(-x_value) : x_value;
          y_mag  <= y_value[31] ? 32'(-y_value) : y_value;
          xy_neg <= x_value[15] ^ y_value[31];
          last_r <= last_point;
        end
      end
      S_PT_ADD: acc <= '0;
      S_MUL: begin
        if (step[0]) begin
          acc <= acc + term_s;
        end
      end
      S_CHK_DEN: begin
        den <= acc[63:0];
        acc <= '0;
        if (den_bad) begin
          slope_r     <= '0;
          intercept_r <= '0;
        end
      end
      S_DIV_LOAD: begin
        div_neg <= div_shift[127];
        acc     <= div_mag;
        rem     <= '0;
      end
      S_DIV_STEP: begin
        // quotient bits shift in at the bottom as the dividend leaves the top
        acc <= {acc[126:0], div_ge};
        rem <= div_ge ? rem_diff[63:0] : rem_ext[63:0];
      end
      S_DIV_RND: acc <= acc + 128'(rnd_up);
      S_DIV_SAT: begin
        acc <= '0;
        if (div_sel) begin
          intercept_r <= sat_val;
        end else begin
          slope_r <= sat_val;
        end
      end
      S_DONE: begin
        if (out_load) begin
          slope     <= slope_r;
          intercept <= intercept_r;
          if (degen) begin
            fit_status <= ST_DEGEN;
          end else if (overflow_seen) begin
            fit_status <= ST_DROP;
          end else begin
            fit_status <= ST_OK;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
